// ----- hw/rtl/sev_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_pkg: shared constants, types and tables for the solar almanac
// Epoch, rates, offsets, CORDIC arctangent table and the cell payload type.
// ----------------------------------------------------------------------------
package sev_pkg;

    localparam int CORDIC_STAGES = 30;
    localparam int TABLE_LEN     = 40;
    localparam int N_CELLS       = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    // epoch 51545.5 days in 2^-24 day units
    localparam logic [44:0] EPOCH_FIXED = 45'd864789987328;
    // turns/day scaled by 2^64
    localparam logic [55:0] RATE_G = 56'd50503100360741887;
    localparam logic [55:0] RATE_L = 56'd50505507790954578;
    localparam logic [31:0] OFS_G  = 32'd45468501;
    localparam logic [31:0] OFS_L  = 32'd3346017846;

    localparam logic signed [25:0] AMP_1   = 26'sd22844752;
    localparam logic signed [25:0] AMP_2   = 26'sd238633;
    localparam logic signed [31:0] COS_OBL = 32'sd985058910;
    localparam logic signed [31:0] SIN_OBL = 32'sd427294056;

    localparam int XW = 42;   // CORDIC x/y width, 38 fraction bits
    localparam int ZW = 34;   // CORDIC residual angle width
    localparam logic signed [XW-1:0] GAIN_START = 42'sd166920415761;

    typedef struct packed {
        logic                 v;
        logic                 flip;
        logic [31:0]          tag;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cell;

    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] r;
        unique case (i)
            0: r = 32'd536870912;  1: r = 32'd316933406;  2: r = 32'd167458907;
            3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
            6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
            9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
            12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
            15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
            18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
            21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
            24: r = 32'd41;        25: r = 32'd20;        26: r = 32'd10;
            27: r = 32'd5;         28: r = 32'd3;         29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // a*b/2^30 rounded, halves up; low 32 bits
    function automatic logic [31:0] rnd_q30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd536870912) >>> 30;
        return t[31:0];
    endfunction

endpackage

// ----- hw/rtl/sev_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_if: date and vector channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface sev_in_if;
    logic        valid;
    logic        ready;
    logic [43:0] mjd_fixed;
    modport source(output valid, output mjd_fixed, input ready);
    modport sink(input valid, input mjd_fixed, output ready);
endinterface

interface sev_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        longitude_turns;
    logic signed [31:0] sun_x;
    logic signed [31:0] sun_y;
    logic signed [31:0] sun_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    modport source(output valid, output longitude_turns, output sun_x, output sun_y,
                   output sun_z, output vel_x, output vel_y, output vel_z, input ready);
    modport sink(input valid, input longitude_turns, input sun_x, input sun_y,
                 input sun_z, input vel_x, input vel_y, input vel_z, output ready);
endinterface

// ----- hw/rtl/sev_phase.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_phase: mean angle from signed day offset
// Bits 87:56 of rate*d via four registered partial products, plus offset.
// ----------------------------------------------------------------------------
module sev_phase
    import sev_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [44:0] i_d,
    input  logic [55:0]        i_rate,
    input  logic [31:0]        i_ofs,
    output logic [31:0]        o_ang
);
    logic [51:0]        r_ll, r_hl;
    logic signed [49:0] r_lh, r_hh;
    logic [87:0]        r_a, r_b;
    logic [87:0]        w_sum;
    logic signed [20:0] w_dh;

    assign w_dh  = i_d[44:24];
    assign w_sum = r_a + r_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= i_rate[27:0] * i_d[23:0];
            r_hl  <= i_rate[55:28] * i_d[23:0];
            r_lh  <= $signed({1'b0, i_rate[27:0]}) * w_dh;
            r_hh  <= $signed({1'b0, i_rate[55:28]}) * w_dh;
            r_a   <= {36'd0, r_ll} + ({36'd0, r_hl} << 28);
            r_b   <= ({{38{r_lh[49]}}, r_lh} << 24) + ({{38{r_hh[49]}}, r_hh} << 52);
            o_ang <= w_sum[87:56] + i_ofs;
        end
    end
endmodule

// ----- hw/rtl/sev_cordic_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_cordic_cell: one CORDIC rotation micro-step
// Rotates by +-atan(2^-shift) toward zero residual; one register stage.
// ----------------------------------------------------------------------------
module sev_cordic_cell
    import sev_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [5:0]  i_shift,
    input  logic [31:0] i_atan,
    input  t_cell       i_s,
    output t_cell       o_s
);
    logic signed [XW-1:0] w_dx, w_dy;
    logic signed [ZW-1:0] w_at;

    assign w_dx = i_s.y >>> i_shift;
    assign w_dy = i_s.x >>> i_shift;
    assign w_at = $signed({2'b00, i_atan});

    // valid is reset; payload only follows the enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_s.v <= 1'b0;
        end else if (i_en) begin
            o_s.v    <= i_s.v;
            o_s.flip <= i_s.flip;
            o_s.tag  <= i_s.tag;
            if (!i_s.z[ZW-1]) begin
                o_s.x <= i_s.x - w_dx;
                o_s.y <= i_s.y + w_dy;
                o_s.z <= i_s.z - w_at;
            end else begin
                o_s.x <= i_s.x + w_dx;
                o_s.y <= i_s.y - w_dy;
                o_s.z <= i_s.z + w_at;
            end
        end
    end
endmodule

// ----- hw/rtl/sev_sincos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_sincos: pipelined sine/cosine of a binary-turn angle
// Quadrant fold, chain of N_CELLS cells, negate and round to Q1.30.
// Fold, cells and output are registered; a 32-bit tag rides along.
// ----------------------------------------------------------------------------
module sev_sincos
    import sev_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [31:0]        i_ang,
    input  logic [31:0]        i_tag,
    output logic               o_valid,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos,
    output logic [31:0]        o_tag
);
    t_cell                w_s [N_CELLS+1];
    t_cell                r_prep;
    logic                 w_flip;
    logic [31:0]          w_r;
    logic signed [XW-1:0] w_x, w_y;

    assign w_flip = i_ang[31] ^ i_ang[30];
    assign w_r    = w_flip ? (i_ang - 32'h8000_0000) : i_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.v <= 1'b0;
        end else if (i_en) begin
            r_prep.v    <= i_valid;
            r_prep.flip <= w_flip;
            r_prep.tag  <= i_tag;
            r_prep.x    <= GAIN_START;
            r_prep.y    <= '0;
            r_prep.z    <= $signed({{(ZW-32){w_r[31]}}, w_r});
        end
    end

    assign w_s[0] = r_prep;

    for (genvar gi = 0; gi < N_CELLS; gi++) begin : g_cell
        sev_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_shift(6'(gi)),
            .i_atan (atan_turns(gi)),
            .i_s    (w_s[gi]),
            .o_s    (w_s[gi+1])
        );
    end

    assign w_x = w_s[N_CELLS].flip ? -w_s[N_CELLS].x : w_s[N_CELLS].x;
    assign w_y = w_s[N_CELLS].flip ? -w_s[N_CELLS].y : w_s[N_CELLS].y;

    function automatic logic signed [31:0] to_q30(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = (v + XW'(128)) >>> 8;
        if (t > XW'(64'sd1073741824)) t = XW'(64'sd1073741824);
        if (t < -XW'(64'sd1073741824)) t = -XW'(64'sd1073741824);
        return t[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= w_s[N_CELLS].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= to_q30(w_x);
            o_sin <= to_q30(w_y);
            o_tag <= w_s[N_CELLS].tag;
        end
    end
endmodule

// ----- hw/rtl/solar_ephemeris_vectors.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solar_ephemeris_vectors: low-precision solar position and motion vectors
// Date in, ecliptic longitude plus sun and earth-motion unit vectors out.
// ----------------------------------------------------------------------------
//  port    | dir | transfer carries
//  i_in    | in  | mjd_fixed (44b, 2^-24 day)
//  o_out   | out | longitude_turns, sun_x/y/z, vel_x/y/z (Q1.30)
//
//  One date per cycle unless the output stalls; the two CORDIC cell chains
//  of 30 stages each lie in series on the path.
//  Reset clears all valid flags; payload registers are not reset.
//  The whole pipeline holds while the output register is full and not taken.
// ----------------------------------------------------------------------------
module solar_ephemeris_vectors
    import sev_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sev_in_if.sink    i_in,
    sev_out_if.source o_out
);
    // global advance: output slot free or being drained
    logic w_adv;
    assign w_adv      = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    // stage 0: day offset from epoch
    logic               r_v0;
    logic signed [44:0] r_d;
    // phase unit valid pipe (3 stages)
    logic [2:0]         r_vp;
    logic [31:0]        w_g, w_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_vp <= '0;
        end else if (w_adv) begin
            r_v0 <= i_in.valid;
            r_vp <= {r_vp[1:0], r_v0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d <= $signed({1'b0, i_in.mjd_fixed} - EPOCH_FIXED);
        end
    end

    sev_phase u_phase_g (
        .i_clk(i_clk), .i_en(w_adv), .i_d(r_d),
        .i_rate(RATE_G), .i_ofs(OFS_G), .o_ang(w_g)
    );
    sev_phase u_phase_l (
        .i_clk(i_clk), .i_en(w_adv), .i_d(r_d),
        .i_rate(RATE_L), .i_ofs(OFS_L), .o_ang(w_l)
    );

    // mean anomaly sines; mean longitude rides as tag
    logic               w_v1;
    logic signed [31:0] w_s1, w_c1, w_s2, w_c2;
    logic [31:0]        w_l1, w_tag2;
    logic               w_v2;

    sev_sincos u_sc_g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(r_vp[2]),
        .i_ang(w_g), .i_tag(w_l),
        .o_valid(w_v1), .o_sin(w_s1), .o_cos(w_c1), .o_tag(w_l1)
    );
    sev_sincos u_sc_2g (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(r_vp[2]),
        .i_ang({w_g[30:0], 1'b0}), .i_tag(w_g),
        .o_valid(w_v2), .o_sin(w_s2), .o_cos(w_c2), .o_tag(w_tag2)
    );

    // equation of center: products, then rounded sum
    logic               r_vm1, r_vm2;
    logic signed [57:0] r_p1, r_p2;
    logic [31:0]        r_lm, r_lon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
            r_vm2 <= 1'b0;
        end else if (w_adv) begin
            r_vm1 <= w_v1 & w_v2;
            r_vm2 <= r_vm1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1  <= AMP_1 * w_s1;
            r_p2  <= AMP_2 * w_s2;
            r_lm  <= w_l1;
            r_lon <= r_lm + rnd_q30(64'(r_p1)) + rnd_q30(64'(r_p2));
        end
    end

    // ecliptic longitude sine/cosine
    logic               w_v3;
    logic signed [31:0] w_sl, w_cl;
    logic [31:0]        w_lon;

    sev_sincos u_sc_lon (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(r_vm2),
        .i_ang(r_lon), .i_tag(r_lon),
        .o_valid(w_v3), .o_sin(w_sl), .o_cos(w_cl), .o_tag(w_lon)
    );

    // obliquity rotation, then rounded output register
    logic               r_vo1;
    logic signed [63:0] r_cs, r_ss, r_cc, r_sc;
    logic signed [31:0] r_sl, r_cl;
    logic [31:0]        r_lo;
    logic               r_vout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo1  <= 1'b0;
            r_vout <= 1'b0;
        end else if (w_adv) begin
            r_vo1  <= w_v3;
            r_vout <= r_vo1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cs <= COS_OBL * w_sl;
            r_ss <= SIN_OBL * w_sl;
            r_cc <= COS_OBL * w_cl;
            r_sc <= SIN_OBL * w_cl;
            r_sl <= w_sl;
            r_cl <= w_cl;
            r_lo <= w_lon;
            o_out.longitude_turns <= r_lo;
            o_out.sun_x <= r_cl;
            o_out.sun_y <= rnd_q30(r_cs);
            o_out.sun_z <= rnd_q30(r_ss);
            o_out.vel_x <= -r_sl;
            o_out.vel_y <= rnd_q30(r_cc);
            o_out.vel_z <= rnd_q30(r_sc);
        end
    end

    assign o_out.valid = r_vout;

    // ---------------- assertions ----------------
    // input side only waits on a full, stalled output slot
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output slot");

    // CORDIC outputs stay saturated to one
    a_sun_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.sun_x <= 32'sd1073741824 &&
                         o_out.sun_x >= -32'sd1073741824 &&
                         o_out.vel_x <= 32'sd1073741824 &&
                         o_out.vel_x >= -32'sd1073741824))
        else $error("unit vector component out of range");

    // the two anomaly lanes travel in lockstep
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v1 == w_v2)
        else $error("sine lanes out of step");

    // a stall freezes the middle of the pipe
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_vm2) && $stable(r_vo1)))
        else $error("pipeline moved during stall");

endmodule

// ----- verif/solar_ephemeris_vectors_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solar_ephemeris_vectors_test: date-stream check of the solar almanac
// Drives dates over the input channel with random gaps and output stalls,
// predicts longitude and both unit vectors in bit-exact integer arithmetic,
// and compares every output transfer in order against the predicted queue.
// ----------------------------------------------------------------------------
module solar_ephemeris_vectors_test;
    import sev_pkg::*;

    typedef struct packed {
        logic [31:0]        lon;
        logic signed [31:0] sx, sy, sz, vx, vy, vz;
    } t_vectors;

    localparam logic [43:0] DATE_MAX = 44'hFFF_FFFF_FFFF;
    localparam int          LATENCY  = 2 * N_CELLS + 12;

    logic i_clk;
    logic i_rst_n;
    sev_in_if  date_ch();
    sev_out_if vec_ch();

    solar_ephemeris_vectors dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (date_ch.sink),
        .o_out  (vec_ch.source)
    );

    t_vectors vec_expected[$];
    int       n_errors;
    int       n_dates;
    int       n_vectors;
    // idle percentage per side; zero during the steady stretch
    int       gap_pct;
    int       stall_pct;
    int       hold_cycles;   // long sink hold-off, counted below

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("timeout at %0t", $time);
        $display("solar_ephemeris_vectors: mismatch");
        $finish;
    end

    // ---------------- predictor ----------------
    // Floor of the exact product rate*(date-epoch)/2^56, wrapped to 32 bits.
    function automatic logic [31:0] mean_phase(logic [55:0] rate, logic [43:0] date);
        logic signed [45:0]  d;
        logic signed [103:0] p;
        d = $signed({2'b00, date}) - $signed({1'b0, EPOCH_FIXED});
        p = $signed({48'd0, rate}) * d;
        return p[87:56];
    endfunction

    function automatic logic signed [63:0] q30_product(logic signed [63:0] a,
                                                      logic signed [63:0] b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [63:0] q30_from_cordic(logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 64'sd128) >>> 8;
        if (r > 64'sd1073741824) r = 64'sd1073741824;
        if (r < -64'sd1073741824) r = -64'sd1073741824;
        return r;
    endfunction

    function automatic logic [31:0] arctan_step(int i);
        case (i)
            0: return 536870912;  1: return 316933406;  2: return 167458907;
            3: return 85004756;   4: return 42667331;   5: return 21354465;
            6: return 10679838;   7: return 5340245;    8: return 2670163;
            9: return 1335087;    10: return 667544;    11: return 333772;
            12: return 166886;    13: return 83443;     14: return 41722;
            15: return 20861;     16: return 10430;     17: return 5215;
            18: return 2608;      19: return 1304;      20: return 652;
            21: return 326;       22: return 163;       23: return 81;
            24: return 41;        25: return 20;        26: return 10;
            27: return 5;         28: return 3;         29: return 1;
            30: return 1;
            default: return 0;
        endcase
    endfunction

    // Rotation CORDIC on a binary-turn angle; quarters two and three are folded.
    task automatic turn_sincos(input logic [31:0] ang,
                               output logic signed [63:0] s,
                               output logic signed [63:0] c);
        logic               flip;
        logic [31:0]        r;
        logic signed [63:0] x, y, z, dx, dy;
        flip = ang[31] ^ ang[30];
        r = flip ? ang - 32'h8000_0000 : ang;
        z = $signed({{32{r[31]}}, r});
        x = 64'sd166920415761;
        y = 0;
        for (int i = 0; i < N_CELLS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = q30_from_cordic(x);
        s = q30_from_cordic(y);
    endtask

    task automatic predict_vectors(input logic [43:0] date, output t_vectors v);
        logic [31:0]        anom, mlon, lon;
        logic signed [63:0] s1, c1, s2, c2, sl, cl, t1, t2;
        anom = OFS_G + mean_phase(RATE_G, date);
        mlon = OFS_L + mean_phase(RATE_L, date);
        turn_sincos(anom, s1, c1);
        turn_sincos(anom << 1, s2, c2);
        t1 = q30_product(22844752, s1);
        t2 = q30_product(238633, s2);
        lon = mlon + t1[31:0] + t2[31:0];
        turn_sincos(lon, sl, cl);
        v.lon = lon;
        v.sx = cl[31:0];
        t1 = q30_product(985058910, sl); v.sy = t1[31:0];
        t1 = q30_product(427294056, sl); v.sz = t1[31:0];
        t1 = -sl;                        v.vx = t1[31:0];
        t1 = q30_product(985058910, cl); v.vy = t1[31:0];
        t1 = q30_product(427294056, cl); v.vz = t1[31:0];
    endtask

    // ---------------- driving ----------------
    // One date transfer; the prediction is queued at acceptance.
    // Valid stays high into the next call; gaps and drains lower it.
    task automatic send_date(input logic [43:0] date);
        t_vectors v;
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            date_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        date_ch.valid     <= 1'b1;
        date_ch.mjd_fixed <= date;
        @(posedge i_clk);
        while (!date_ch.ready) @(posedge i_clk);
        predict_vectors(date, v);
        vec_expected.push_back(v);
        n_dates++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        date_ch.valid <= 1'b0;
        while (vec_expected.size() != 0) @(negedge i_clk);
    endtask

    // Sink ready: random stalls, plus a counted hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            vec_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else begin
            vec_ch.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    // ---------------- checking ----------------
    always @(posedge i_clk) begin
        t_vectors e, a;
        if (i_rst_n && vec_ch.valid && vec_ch.ready) begin
            a = '{vec_ch.longitude_turns, vec_ch.sun_x, vec_ch.sun_y, vec_ch.sun_z,
                  vec_ch.vel_x, vec_ch.vel_y, vec_ch.vel_z};
            n_vectors++;
            if (vec_expected.size() == 0) begin
                $display("%0t: unexpected result %h", $time, a);
                n_errors++;
            end else begin
                e = vec_expected.pop_front();
                if (e.lon != a.lon) begin
                    $display("%0t: longitude exp %h got %h", $time, e.lon, a.lon);
                    n_errors++;
                end
                if (e.sx != a.sx || e.sy != a.sy || e.sz != a.sz) begin
                    $display("%0t: sun exp %0d %0d %0d got %0d %0d %0d", $time,
                             e.sx, e.sy, e.sz, a.sx, a.sy, a.sz);
                    n_errors++;
                end
                if (e.vx != a.vx || e.vy != a.vy || e.vz != a.vz) begin
                    $display("%0t: vel exp %0d %0d %0d got %0d %0d %0d", $time,
                             e.vx, e.vy, e.vz, a.vx, a.vy, a.vz);
                    n_errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    // Date extremes, the epoch and neighbors, and a year of dates 32 days apart.
    task automatic test_directed_dates();
        logic [43:0] epoch;
        epoch = EPOCH_FIXED[43:0];
        send_date('0);
        send_date(DATE_MAX);
        send_date(44'h800_0000_0000);
        send_date(44'h7FF_FFFF_FFFF);
        send_date(epoch);
        send_date(epoch - 1);        // just before the epoch, negative offset
        send_date(epoch + 1);
        send_date(44'hAAA_AAAA_AAAA);
        send_date(44'h555_5555_5555);
        send_date(44'd1);
        // longitude sweeps all quarters over a year
        for (int q = 0; q < 12; q++) send_date(epoch + 44'(q) * 44'd32 * (44'd1 << 24));
        wait_drained();
    endtask

    // Mostly dates in the modern range, some over the full 44 bits.
    task automatic test_random_dates(input int count);
        logic [43:0] date;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(3) == 0)
                date = 44'({$urandom, $urandom}); // full range, every bit
            else
                date = EPOCH_FIXED[43:0] + {8'd0, 12'($urandom_range(4095)), 24'd0}
                       - {8'd0, 12'd2048, 24'd0} + 44'($urandom);
            send_date(date);
        end
    endtask

    // Sink holds off while dates keep coming, so the pipeline backs up.
    task automatic test_backpressure();
        hold_cycles = 200;
        gap_pct = 0;
        for (int k = 0; k < 150; k++) send_date(44'({$urandom, $urandom}));
        gap_pct = 32;
        wait_drained();
    endtask

    initial begin
        n_errors = 0; n_dates = 0; n_vectors = 0;
        gap_pct = 32; stall_pct = 32; hold_cycles = 0;
        i_rst_n = 1'b0;
        date_ch.valid = 1'b0;
        date_ch.mjd_fixed = '0;
        vec_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_dates();
        test_random_dates(700);
        wait_drained();              // sender pauses until all results are back
        gap_pct = 0; stall_pct = 0;  // full-rate stretch
        test_random_dates(400);
        gap_pct = 32; stall_pct = 32;
        test_backpressure();
        test_random_dates(580);

        wait_drained();
        repeat (LATENCY + 20) @(negedge i_clk);
        $display("covered %0d dates and %0d vector results, with stalls and a full pipe",
                 n_dates, n_vectors);
        if (n_errors == 0 && vec_expected.size() == 0) begin
            $display("solar_ephemeris_vectors: match");
        end else begin
            $display("solar_ephemeris_vectors: mismatch");
        end
        $finish;
    end
endmodule
